/* src/rrts_pkg.sv */
// Package for the round-robin task scheduler: payload structs, operation codes,
// task states and the command/status structs between controller and datapath.
`timescale 1ns / 1ps
package rrts_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_YIELD = 2'd2,
    OP_SLEEP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_READY = 2'd1,
    ST_SLEEP = 2'd2
  } task_st_e;

  localparam int unsigned SliceW  = 16;
  localparam int unsigned SleepW  = 17;
  localparam logic [SleepW-1:0] SleepMax = '1;
  localparam logic [SliceW-1:0] SliceReset = 16'd10;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  task_id;
    logic [19:0] sleep_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0] running_task;
    logic       running_idle;
    logic       switched;
    logic [4:0] ready_count;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic start;      // Latch the item and trigger the operation phase.
    logic scan;       // Process one sleeper.
    logic finish;     // Dispatch and form the result.
  } rrts_cmd_t;

  typedef struct packed {
    logic need_scan;  // The item is a tick with sleepers to visit.
    logic scan_last;  // The current sleeper is the last.
  } rrts_sts_t;

endpackage

/* src/rrts_ctrl.sv */
// Controller of the round-robin task scheduler: sequences operation, sleeper
// scan and result. Depends on rrts_pkg.
`timescale 1ns / 1ps
module rrts_ctrl import rrts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  rrts_sts_t sts_i,
  output rrts_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OP   = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d      = state_q;
    ovalid_d     = ovalid_q && !out_ready_i;
    cmd_o        = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.start = 1'b1;
          state_d = S_OP;
        end
      end
      S_OP: begin
        state_d = sts_i.need_scan ? S_SCAN : S_FIN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

/* src/rrts_dp.sv */
// Datapath of the round-robin task scheduler: ready queue, sleep list, slice
// and sleep counters, task states. Depends on rrts_pkg.
`timescale 1ns / 1ps
module rrts_dp import rrts_pkg::*; #(
  parameter int unsigned TASKS       = 16,
  parameter int unsigned MS_PER_TICK = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    item_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  rrts_cmd_t   cmd_i,
  output rrts_sts_t   sts_o,
  output out_item_t   out_o
);

  localparam int unsigned IdW  = $clog2(TASKS + 1);
  localparam int unsigned CntW = $clog2(TASKS + 1);
  localparam int unsigned IxW  = $clog2(TASKS);
  localparam logic [IdW-1:0]  IdleId = IdW'(TASKS);
  localparam logic [CntW-1:0] TasksC = CntW'(TASKS);
  localparam logic [31:0] Recip =
    32'(((64'd1 << 31) + 64'(MS_PER_TICK) - 64'd1) / 64'(MS_PER_TICK));

  logic [SliceW-1:0] slice_len_q;
  in_item_t          item_q;
  logic [IdW-1:0]    before_q;
  logic              rej_q;
  logic [IxW-1:0]    rq_q [TASKS];
  logic [IxW-1:0]    so_q [TASKS];
  logic [CntW-1:0]   rlen_q, slen_q, kept_q, scan_q;
  logic [SliceW-1:0] slice_q [TASKS+1];
  logic [SleepW-1:0] sleep_q [TASKS];
  task_st_e          st_q [TASKS];
  logic [IdW-1:0]    cur_q;
  out_item_t         out_q;
  logic [SleepW-1:0] ticks_q;
  logic              op_pend_q;

  logic [IdW-1:0]    cur_c;
  logic [SliceW-1:0] dec_c;
  logic [IxW-1:0]    sl_t;
  logic [SleepW-1:0] sl_dec;
  logic [20:0]       q_w;
  logic [51:0]       prod_w;
  logic [20:0]       quo_w;
  logic [IxW-1:0]    tid_c;

  assign out_o = out_q;
  assign sts_o.need_scan = (item_q.operation == OP_TICK) && (slen_q != '0);
  assign sts_o.scan_last = (scan_q + 1'b1) == slen_q;

  assign cur_c  = cur_q;
  assign dec_c  = slice_q[cur_c] - 1'b1;
  assign sl_t   = so_q[scan_q[IxW-1:0]];
  assign sl_dec = sleep_q[sl_t] - 1'b1;
  assign q_w    = 21'(item_i.sleep_ms) + 21'(MS_PER_TICK - 1);
  assign prod_w = 52'(q_w) * 52'(Recip);
  assign quo_w  = prod_w[51:31];
  assign tid_c  = IxW'(item_q.task_id);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_len_q <= SliceReset;
      rlen_q <= '0;
      slen_q <= '0;
      cur_q  <= IdleId;
      for (int i = 0; i <= TASKS; i++) slice_q[i] <= SliceReset;
      for (int i = 0; i < TASKS; i++) begin
        sleep_q[i] <= '0;
        st_q[i] <= ST_FREE;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_i) slice_len_q <= cfg_data_i;
      if (cmd_i.start) begin
        item_q   <= item_i;
        before_q <= cur_q;
        ticks_q  <= (quo_w > 21'(SleepMax)) ? SleepMax : SleepW'(quo_w);
      end
      // Operation phase: the cycle after start.
      if (!cmd_i.start && !cmd_i.scan && !cmd_i.finish && op_pend_q) begin
        rej_q  <= 1'b0;
        scan_q <= '0;
        kept_q <= '0;
        case (item_q.operation)
          OP_TICK: begin
            if (dec_c == '0) begin
              slice_q[cur_c] <= slice_len_q;
              if (cur_q != IdleId && rlen_q != '0) begin
                for (int i = 0; i < TASKS - 1; i++) rq_q[i] <= rq_q[i+1];
                rq_q[rlen_q[IxW-1:0] - 1'b1] <= rq_q[0];
              end
            end else begin
              slice_q[cur_c] <= dec_c;
            end
          end
          OP_START: begin
            if (st_q[tid_c] != ST_FREE || 32'(item_q.task_id) >= TASKS) begin
              rej_q <= 1'b1;
            end else begin
              st_q[tid_c] <= ST_READY;
              slice_q[tid_c] <= slice_len_q;
              rq_q[rlen_q[IxW-1:0]] <= tid_c;
              rlen_q <= rlen_q + 1'b1;
            end
          end
          OP_YIELD: begin
            if (rlen_q > CntW'(1) && cur_q != IdleId) begin
              for (int i = 0; i < TASKS - 1; i++) rq_q[i] <= rq_q[i+1];
              rq_q[rlen_q[IxW-1:0] - 1'b1] <= rq_q[0];
            end
          end
          OP_SLEEP: begin
            if (cur_q == IdleId || rlen_q == '0) begin
              rej_q <= 1'b1;
            end else if (ticks_q != '0 && slen_q < TasksC) begin
              st_q[rq_q[0]] <= ST_SLEEP;
              sleep_q[rq_q[0]] <= ticks_q;
              so_q[slen_q[IxW-1:0]] <= rq_q[0];
              slen_q <= slen_q + 1'b1;
              for (int i = 0; i < TASKS - 1; i++) rq_q[i] <= rq_q[i+1];
              rlen_q <= rlen_q - 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.scan) begin
        scan_q <= scan_q + 1'b1;
        sleep_q[sl_t] <= sl_dec;
        if (sl_dec == '0) begin
          st_q[sl_t] <= ST_READY;
          rq_q[rlen_q[IxW-1:0]] <= sl_t;
          rlen_q <= rlen_q + 1'b1;
        end else begin
          so_q[kept_q[IxW-1:0]] <= sl_t;
          kept_q <= kept_q + 1'b1;
        end
        if (sts_o.scan_last) slen_q <= kept_q + CntW'(sl_dec != '0);
      end
      if (cmd_i.finish) begin
        cur_q <= (rlen_q != '0) ? IdW'(rq_q[0]) : IdleId;
        out_q.running_idle <= (rlen_q == '0);
        out_q.running_task <= (rlen_q != '0) ? 4'(rq_q[0]) : 4'd0;
        out_q.switched <= ((rlen_q != '0) ? IdW'(rq_q[0]) : IdleId) != before_q;
        out_q.ready_count <= 5'(rlen_q);
        out_q.rejected <= rej_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) op_pend_q <= 1'b0;
    else op_pend_q <= cmd_i.start;
  end

endmodule

/* src/round_robin_task_scheduler.sv */
// Round-robin task scheduler: one result beat per input beat.
// The input item is latched when accepted; then come the operation phase, for
// a tick with sleepers the one-sleeper-per-cycle scan, and the finish step that
// registers the result. No new item is taken until the controller is idle; a
// stalled result holds the next item at its last step. Reset (asynchronous,
// active low): queue empty, idle running, all tasks free, slices and slice_length 10.
`timescale 1ns / 1ps
module round_robin_task_scheduler import rrts_pkg::*; #(
  parameter int unsigned TASKS       = 16,
  parameter int unsigned MS_PER_TICK = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  rrts_cmd_t cmd;
  rrts_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rrts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rrts_dp #(.TASKS(TASKS), .MS_PER_TICK(MS_PER_TICK)) u_dp (
    .clk_i, .rst_ni,
    .item_i      (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_data_o)
  );

endmodule
